// ===== rtl/owm_pkg.sv =====
`timescale 1ns / 1ps

package owm_pkg;

  localparam int COUNT_W = 10;
  localparam int CFG_IDX_W = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] READ_LOW_TIME = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] BYTE_GAP_TIME = COUNT_W'(220);

  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_SAMPLE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_WR_ONE_LOW   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_WR_ZERO_LOW  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_WR_SLOT      = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_RD_SAMPLE    = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_RD_RECOVER   = CFG_IDX_W'(7);

  localparam logic [1:0] FUNC_NONE  = 2'd0;
  localparam logic [1:0] FUNC_RESET = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_RESET,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       line_level;
  } in_word_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_level;
    logic [7:0] read_data;
  } out_word_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       line_level;
  } tick_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] reset_low_time;
    logic [COUNT_W-1:0] presence_sample_time;
    logic [COUNT_W-1:0] reset_tail_time;
    logic [COUNT_W-1:0] write_one_low_time;
    logic [COUNT_W-1:0] write_zero_low_time;
    logic [COUNT_W-1:0] write_slot_time;
    logic [COUNT_W-1:0] read_sample_time;
    logic [COUNT_W-1:0] read_recover_time;
  } cfg_t;

  localparam cfg_t CFG_RESET_VALUE = '{
    reset_low_time:       COUNT_W'(500),
    presence_sample_time: COUNT_W'(75),
    reset_tail_time:      COUNT_W'(545),
    write_one_low_time:   COUNT_W'(10),
    write_zero_low_time:  COUNT_W'(120),
    write_slot_time:      COUNT_W'(140),
    read_sample_time:     COUNT_W'(14),
    read_recover_time:    COUNT_W'(230)
  };

endpackage

// ===== rtl/owm_front.sv =====
`timescale 1ns / 1ps

module owm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  owm_pkg::in_word_t   in_word,
  output logic                q_valid,
  output owm_pkg::tick_word_t q_word,
  input  logic                q_pop
);

  owm_pkg::tick_word_t entries [owm_pkg::QUEUE_DEPTH];
  logic [owm_pkg::QPTR_W-1:0] wr_ptr;
  logic [owm_pkg::QPTR_W-1:0] rd_ptr;
  logic [owm_pkg::QCNT_W-1:0] count;
  owm_pkg::tick_word_t        word_next;
  logic                       push;

  assign in_stall = (count == owm_pkg::QCNT_W'(owm_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_word   = entries[rd_ptr];

  always_comb begin
    unique case (in_word.func)
      owm_pkg::FUNC_RESET: word_next.cmd = owm_pkg::CMD_RESET;
      owm_pkg::FUNC_WRITE: word_next.cmd = owm_pkg::CMD_WRITE;
      owm_pkg::FUNC_READ:  word_next.cmd = owm_pkg::CMD_READ;
      default:             word_next.cmd = owm_pkg::CMD_NONE;
    endcase
    word_next.data_byte  = in_word.data_byte;
    word_next.line_level = in_word.line_level;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == owm_pkg::QPTR_W'(owm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == owm_pkg::QPTR_W'(owm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + owm_pkg::QCNT_W'(push) - owm_pkg::QCNT_W'(q_pop);
    end
  end

endmodule

// ===== rtl/owm_back.sv =====
`timescale 1ns / 1ps

module owm_back (
  input  logic                clk,
  input  logic                rst,
  input  owm_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  owm_pkg::tick_word_t q_word,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output owm_pkg::out_word_t  out_word
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_REL,
    PH_RST_TAIL,
    PH_WR_SLOT,
    PH_WR_GAP,
    PH_RD_SLOT,
    PH_RD_REC
  } phase_t;

  phase_t                      phase, phase_e, phase_next;
  logic [owm_pkg::COUNT_W-1:0] tick_count, tc_e, tick_count_next, tc_inc;
  logic [2:0]                  bit_index, bit_e, bit_index_next;
  logic [7:0]                  shift_byte, shift_e, shift_byte_next;
  logic                        presence_bit, presence_bit_next;
  logic [7:0]                  read_byte_reg, read_byte_reg_next;
  logic                        drive, busy, done;
  logic [owm_pkg::COUNT_W-1:0] wr_low;
  owm_pkg::out_word_t          res;

  function automatic logic last_tick(input logic [owm_pkg::COUNT_W-1:0] tc,
                                     input logic [owm_pkg::COUNT_W-1:0] dur);
    return ({1'b0, tc} + (owm_pkg::COUNT_W + 1)'(1)) >= {1'b0, dur};
  endfunction

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    phase_e = phase;
    tc_e    = tick_count;
    bit_e   = bit_index;
    shift_e = shift_byte;
    if (phase == PH_IDLE) begin
      bit_e = '0;
      unique case (q_word.cmd)
        owm_pkg::CMD_RESET: begin
          phase_e = PH_RST_LOW;
          tc_e    = '0;
        end
        owm_pkg::CMD_WRITE: begin
          shift_e = q_word.data_byte;
          phase_e = PH_WR_SLOT;
          tc_e    = '0;
        end
        owm_pkg::CMD_READ: begin
          shift_e = '0;
          phase_e = PH_RD_SLOT;
          tc_e    = '0;
        end
        default: ;
      endcase
    end
    busy   = (phase_e != PH_IDLE);
    tc_inc = tc_e + owm_pkg::COUNT_W'(1);
    wr_low = shift_e[0] ? cfg.write_one_low_time : cfg.write_zero_low_time;

    phase_next         = phase_e;
    tick_count_next    = tc_e;
    bit_index_next     = bit_e;
    shift_byte_next    = shift_e;
    presence_bit_next  = presence_bit;
    read_byte_reg_next = read_byte_reg;
    drive              = 1'b0;
    done               = 1'b0;

    unique case (phase_e)
      PH_RST_LOW: begin
        drive = 1'b1;
        if (last_tick(tc_e, cfg.reset_low_time)) begin
          phase_next      = PH_RST_REL;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_RST_REL: begin
        if (tc_e >= cfg.presence_sample_time) begin
          presence_bit_next = q_word.line_level;
          tick_count_next   = '0;
          if (cfg.reset_tail_time == '0) begin
            phase_next     = PH_IDLE;
            bit_index_next = '0;
            done           = 1'b1;
          end else begin
            phase_next = PH_RST_TAIL;
          end
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_RST_TAIL: begin
        if (last_tick(tc_e, cfg.reset_tail_time)) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          bit_index_next  = '0;
          done            = 1'b1;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_WR_SLOT: begin
        drive = (tc_e < wr_low);
        if (last_tick(tc_e, cfg.write_slot_time)) begin
          shift_byte_next = {1'b0, shift_e[7:1]};
          tick_count_next = '0;
          if (bit_e == 3'd7) begin
            if (owm_pkg::BYTE_GAP_TIME == '0) begin
              phase_next     = PH_IDLE;
              bit_index_next = '0;
              done           = 1'b1;
            end else begin
              phase_next = PH_WR_GAP;
            end
          end else begin
            bit_index_next = bit_e + 3'd1;
            phase_next     = PH_WR_SLOT;
          end
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_WR_GAP: begin
        if (last_tick(tc_e, owm_pkg::BYTE_GAP_TIME)) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          bit_index_next  = '0;
          done            = 1'b1;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_RD_SLOT: begin
        drive = (tc_e < owm_pkg::READ_LOW_TIME) && (tc_e < cfg.read_sample_time);
        if (tc_e >= cfg.read_sample_time) begin
          shift_byte_next = shift_e | (8'({7'b0, q_word.line_level}) << bit_e);
          tick_count_next = '0;
          if (cfg.read_recover_time == '0) begin
            if (bit_e == 3'd7) begin
              read_byte_reg_next = shift_byte_next;
              phase_next         = PH_IDLE;
              bit_index_next     = '0;
              done               = 1'b1;
            end else begin
              bit_index_next = bit_e + 3'd1;
              phase_next     = PH_RD_SLOT;
            end
          end else begin
            phase_next = PH_RD_REC;
          end
        end else begin
          tick_count_next = tc_inc;
        end
      end
      PH_RD_REC: begin
        if (last_tick(tc_e, cfg.read_recover_time)) begin
          tick_count_next = '0;
          if (bit_e == 3'd7) begin
            read_byte_reg_next = shift_e;
            phase_next         = PH_IDLE;
            bit_index_next     = '0;
            done               = 1'b1;
          end else begin
            bit_index_next = bit_e + 3'd1;
            phase_next     = PH_RD_SLOT;
          end
        end else begin
          tick_count_next = tc_inc;
        end
      end
      default: ;
    endcase

    res.drive_low      = drive;
    res.busy_res       = busy;
    res.done_res       = done;
    res.presence_level = presence_bit_next;
    res.read_data      = read_byte_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_bit  <= 1'b1;
      read_byte_reg <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        presence_bit  <= presence_bit_next;
        read_byte_reg <= read_byte_reg_next;
        out_word      <= res;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/one_wire_master_byte_engine_core.sv =====
`timescale 1ns / 1ps
// 1-Wire bus master byte engine, stepped by one input word per microsecond tick.
// Input channel (in_valid/in_stall/in_word): func selects none, reset with
// presence detect, write byte or read byte (LSB first); line_level is the sampled
// bus level. A command is taken only when the engine is idle, else ignored.
// Output channel (out_valid/out_stall/out_word): one word per input word, with
// drive_low (open-drain pull-down), busy, a done pulse, the presence level of
// the last reset and the byte of the last completed read.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the eight slot
// timing registers; cfg_ready is always high, writes belong in idle periods.
// An accepted word is held in the queue, then popped into the output register.
// Throughput: one word per cycle; the two-entry queue between the classifier
// and the timing sequencer holds words while out_stall is high, and in_stall
// rises once both entries are full.
// Reset clears the queue, the output valid flag and the sequencer (idle, presence
// level 1, read byte 0) and loads the default slot timings.

module one_wire_master_byte_engine_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  owm_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output owm_pkg::out_word_t                out_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [owm_pkg::COUNT_W-1:0]       cfg_data
);

  owm_pkg::cfg_t       cfg;
  logic                q_valid;
  owm_pkg::tick_word_t q_word;
  logic                q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= owm_pkg::CFG_RESET_VALUE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        owm_pkg::CFG_RESET_LOW:   cfg.reset_low_time       <= cfg_data;
        owm_pkg::CFG_PRES_SAMPLE: cfg.presence_sample_time <= cfg_data;
        owm_pkg::CFG_RESET_TAIL:  cfg.reset_tail_time      <= cfg_data;
        owm_pkg::CFG_WR_ONE_LOW:  cfg.write_one_low_time   <= cfg_data;
        owm_pkg::CFG_WR_ZERO_LOW: cfg.write_zero_low_time  <= cfg_data;
        owm_pkg::CFG_WR_SLOT:     cfg.write_slot_time      <= cfg_data;
        owm_pkg::CFG_RD_SAMPLE:   cfg.read_sample_time     <= cfg_data;
        owm_pkg::CFG_RD_RECOVER:  cfg.read_recover_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  owm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  owm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.done_res |-> out_word.busy_res)
    else $error("done without busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.drive_low |-> out_word.busy_res)
    else $error("bus driven while idle");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.done_res && !out_stall |=> !(out_valid && out_word.done_res))
    else $error("done on consecutive words");

  a_pop_room: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && !(out_valid && out_stall))
    else $error("queue popped without room");

endmodule
